### rtl/rmst_pkg.sv
// Shared types and constants for the range minimum segment tree.
package rmst_pkg;
  localparam int LEAF_COUNT = 1024;
  localparam int IDX_W = $clog2(LEAF_COUNT);
  localparam int NODE_W = IDX_W + 1;
  localparam int CNT_W = 11;
  localparam int DATA_W = 32;
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PADD  = 2'd1,
    OP_RADD  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    // top two bits differ on overflow; the top bit gives its direction
    if (s[DATA_W] != s[DATA_W-1]) sat_add = s[DATA_W] ? VAL_MIN : VAL_MAX;
    else sat_add = s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] smin(
    input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    smin = (a < b) ? a : b;
  endfunction
endpackage

### rtl/rmst_ram.sv
// Generic single-port synchronous RAM with registered read.
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/range_min_segment_tree.sv
// Top level: segment tree sequencer over one node memory.
//
// Usage: items arrive on valid/stall with op, low_index, high_index, value.
// op 0 loads an element, 1 adds to one element, 2 adds to a range, 3 queries
// the range minimum; only a query produces a transfer on min_value.
// element_count is written through cfg_we/cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// After reset a clearing pass writes the largest value to all 2*LEAF_COUNT
// nodes, one per cycle; no input is taken meanwhile. One item is worked at
// a time; all work goes through the single memory port, and a read presents
// its address one cycle and uses the data the next.
// Load / point add: the leaf is read and written, then each ancestor over
// log2(LEAF_COUNT) levels reads both children and writes their minimum.
// Query: per level, up to two boundary nodes are each read and folded in,
// then the walk climbs; the result waits in S_OUT. Range add: every
// leaf in range is read and written; ancestors are rebuilt level by level.
// A finished query result sits in an output register; in_stall stays high
// until out_stall lets it go, so nothing is lost when the receiver stalls.
module range_min_segment_tree
  import rmst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               op,
  input  logic [IDX_W-1:0]         low_index,
  input  logic [IDX_W-1:0]         high_index,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] min_value
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LEAF_RD, S_LEAF_WR, S_UP_RD0, S_UP_RD1, S_UP_WR,
    S_Q_STEP, S_Q_RD, S_Q_ACC, S_OUT
  } state_t;

  state_t state;
  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] cnt_eff;
  logic [1:0] cur_op;
  logic signed [DATA_W-1:0] inc;
  logic [NODE_W-1:0] lo_n, hi_n, node_k, clr_addr;
  logic [NODE_W:0] q_l, q_r;
  logic signed [DATA_W-1:0] acc, child0;
  logic q_from_r;

  logic we;
  logic [NODE_W-1:0] addr;
  logic signed [DATA_W-1:0] wdata, rdata;

  rmst_ram #(.WIDTH(DATA_W), .DEPTH(2 * LEAF_COUNT)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign cnt_eff = (element_count > CNT_W'(LEAF_COUNT)) ? CNT_W'(LEAF_COUNT)
                                                         : element_count;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign min_value = acc;

  // high element index, clipped to cnt_eff - 1 unless no element is in use
  logic [CNT_W-1:0] hi_clip;
  logic accept;
  assign accept = in_valid && (state == S_IDLE);
  always_comb begin
    hi_clip = {1'b0, high_index};
    if (cnt_eff != '0 && hi_clip > cnt_eff - 1'b1) hi_clip = cnt_eff - 1'b1;
  end

  always_comb begin
    we = 1'b0;
    addr = node_k;
    wdata = acc;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        addr = clr_addr;
        wdata = VAL_MAX;
      end
      S_LEAF_WR: begin
        we = 1'b1;
        wdata = (op_t'(cur_op) == OP_LOAD) ? inc : sat_add(rdata, inc);
      end
      S_UP_RD0: addr = {node_k[NODE_W-2:0], 1'b0};
      S_UP_RD1: addr = {node_k[NODE_W-2:0], 1'b1};
      S_UP_WR: begin
        we = 1'b1;
        wdata = smin(child0, rdata);
      end
      S_Q_RD: addr = q_from_r ? q_r[NODE_W-1:0] - 1'b1 : q_l[NODE_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      element_count <= CNT_W'(LEAF_COUNT);
    end else begin
      if (cfg_we) element_count <= cfg_data;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == NODE_W'(2 * LEAF_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          cur_op <= op;
          inc <= value;
          acc <= VAL_MAX;
          lo_n <= NODE_W'(LEAF_COUNT) + NODE_W'(low_index);
          // a single-element update ends on its own leaf
          hi_n <= NODE_W'(LEAF_COUNT) + ((op_t'(op) == OP_RADD) ? NODE_W'(hi_clip)
                                                                : NODE_W'(low_index));
          node_k <= NODE_W'(LEAF_COUNT) + NODE_W'(low_index);
          q_l <= (NODE_W + 1)'(LEAF_COUNT) + (NODE_W + 1)'(low_index);
          q_r <= (NODE_W + 1)'(LEAF_COUNT) + (NODE_W + 1)'(hi_clip) + 1'b1;
          q_from_r <= 1'b0;
          if (op_t'(op) == OP_QUERY) begin
            if (cnt_eff == '0 || {1'b0, low_index} > hi_clip) state <= S_OUT;
            else state <= S_Q_STEP;
          end else if (op_t'(op) == OP_RADD) begin
            if (cnt_eff != '0 && {1'b0, low_index} <= hi_clip) state <= S_LEAF_RD;
          end else if ({1'b0, low_index} < cnt_eff) begin
            state <= S_LEAF_RD;
          end
        end
        S_LEAF_RD: state <= S_LEAF_WR;
        S_LEAF_WR: begin
          if (node_k != hi_n) begin
            node_k <= node_k + 1'b1;
            state <= S_LEAF_RD;
          end else begin
            lo_n <= lo_n >> 1;
            hi_n <= hi_n >> 1;
            node_k <= lo_n >> 1;
            state <= S_UP_RD0;
          end
        end
        S_UP_RD0: state <= S_UP_RD1;
        S_UP_RD1: begin
          child0 <= rdata;
          state <= S_UP_WR;
        end
        S_UP_WR: begin
          if (node_k != hi_n) begin
            node_k <= node_k + 1'b1;
            state <= S_UP_RD0;
          end else if (hi_n == NODE_W'(1)) begin
            state <= S_IDLE;
          end else begin
            lo_n <= lo_n >> 1;
            hi_n <= hi_n >> 1;
            node_k <= lo_n >> 1;
            state <= S_UP_RD0;
          end
        end
        S_Q_STEP: begin
          // pick the next boundary node to fold in, climb a level, or finish
          if (q_l >= q_r) state <= S_OUT;
          else if (q_l[0]) begin
            q_from_r <= 1'b0;
            state <= S_Q_RD;
          end else if (q_r[0]) begin
            q_from_r <= 1'b1;
            state <= S_Q_RD;
          end else begin
            q_l <= q_l >> 1;
            q_r <= q_r >> 1;
          end
        end
        S_Q_RD: state <= S_Q_ACC;
        S_Q_ACC: begin
          acc <= smin(acc, rdata);
          if (q_from_r) q_r <= q_r - 1'b1;
          else q_l <= q_l + 1'b1;
          state <= S_Q_STEP;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // a query result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(min_value))
    else $error("result changed under stall");
  // no input transfer while a result waits
  a_no_accept_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken with pending result");
  // the memory is only written during clear or an update
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_CLEAR || state == S_LEAF_WR || state == S_UP_WR))
    else $error("stray memory write");
  // the update walk never leaves its level range
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_RD0) |-> (node_k >= lo_n && node_k <= hi_n))
    else $error("update walk out of range");
endmodule

### test/tb.sv
// Testbench for range_min_segment_tree: directed and random ops checked by a tree predictor.
`timescale 1ns / 1ps

module tb;
  import rmst_pkg::*;

  localparam int SETTLE_CYCLES = 12000;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    op_t                     op;
    logic [IDX_W-1:0]        lo;
    logic [IDX_W-1:0]        hi;
    logic signed [DATA_W-1:0] val;
  } tree_op_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [IDX_W-1:0] low_index = '0;
  logic [IDX_W-1:0] high_index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [DATA_W-1:0] min_value;

  range_min_segment_tree u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .low_index(low_index),
    .high_index(high_index), .value(value), .out_valid(out_valid),
    .out_stall(out_stall), .min_value(min_value)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // predictor state
  logic signed [DATA_W-1:0] node_mirror [2*LEAF_COUNT];
  int unsigned used_elems = 1024;
  logic signed [DATA_W-1:0] min_q [$];
  tree_op_t pending [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_output = 0;
  bit took = 0;
  int errors = 0;
  int queries_seen = 0;
  int items_sent = 0;
  longint cycles = 0;

  function automatic logic signed [DATA_W-1:0] clamp_sum(
    logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[DATA_W-1:0];
  endfunction

  function automatic void rebuild_above(int lo, int hi);
    int l, h;
    l = (lo + LEAF_COUNT) >> 1;
    h = (hi + LEAF_COUNT) >> 1;
    while (h >= 1) begin
      if (l < 1) l = 1;
      for (int k = l; k <= h; k++)
        node_mirror[k] = (node_mirror[2*k] < node_mirror[2*k+1]) ?
                         node_mirror[2*k] : node_mirror[2*k+1];
      l >>= 1;
      h >>= 1;
    end
  endfunction

  function automatic void apply_tree_op(tree_op_t t);
    int cnt, lo, hi, l, r;
    logic signed [DATA_W-1:0] m;
    cnt = (used_elems > LEAF_COUNT) ? LEAF_COUNT : used_elems;
    lo = t.lo;
    hi = t.hi;
    if (t.op == OP_LOAD || t.op == OP_PADD) begin
      if (lo < cnt) begin
        if (t.op == OP_LOAD) node_mirror[lo + LEAF_COUNT] = t.val;
        else node_mirror[lo + LEAF_COUNT] = clamp_sum(node_mirror[lo + LEAF_COUNT], t.val);
        rebuild_above(lo, lo);
      end
      return;
    end
    if (cnt == 0) begin
      if (t.op == OP_QUERY) min_q.push_back(VAL_MAX);
      return;
    end
    if (hi > cnt - 1) hi = cnt - 1;
    if (t.op == OP_RADD) begin
      if (lo > hi) return;
      for (int k = lo; k <= hi; k++)
        node_mirror[k + LEAF_COUNT] = clamp_sum(node_mirror[k + LEAF_COUNT], t.val);
      rebuild_above(lo, hi);
      return;
    end
    m = VAL_MAX;
    if (lo <= hi) begin
      l = lo + LEAF_COUNT;
      r = hi + LEAF_COUNT + 1;
      while (l < r) begin
        if (l[0]) begin
          if (node_mirror[l] < m) m = node_mirror[l];
          l++;
        end
        if (r[0]) begin
          r--;
          if (node_mirror[r] < m) m = node_mirror[r];
        end
        l >>= 1;
        r >>= 1;
      end
    end
    min_q.push_back(m);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0: return VAL_MAX - $urandom_range(3);
      1: return VAL_MIN + $urandom_range(3);
      2: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic tree_op_t random_tree_op(int span);
    tree_op_t t;
    int pick;
    pick = $urandom_range(99);
    t.val = pick_value();
    t.lo = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(span - 1));
    t.hi = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(span - 1));
    if (pick < 30) t.op = OP_LOAD;
    else if (pick < 50) t.op = OP_PADD;
    else if (pick < 65) begin
      t.op = OP_RADD;
      // keep range adds short; a full sweep now and then
      if ($urandom_range(49) == 0) begin
        t.lo = '0;
        t.hi = '1;
      end else if ($urandom_range(7) != 0) begin
        t.hi = t.lo + IDX_W'($urandom_range(7));
      end
    end else t.op = OP_QUERY;
    return t;
  endfunction

  function automatic void queue_op(op_t o, int lo, int hi, logic signed [DATA_W-1:0] v);
    tree_op_t t;
    t.op = o;
    t.lo = IDX_W'(lo);
    t.hi = IDX_W'(hi);
    t.val = v;
    pending.push_back(t);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || took)) begin
      if (pending.size() > 0 && !(send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)) begin
        tree_op_t t;
        t = pending.pop_front();
        in_valid <= 1;
        op <= t.op;
        low_index <= t.lo;
        high_index <= t.hi;
        value <= t.val;
      end else begin
        in_valid <= 0;
      end
    end
    out_stall <= hold_output || (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // accepted transfers: predict on input, check on output
  always @(posedge clk) begin
    took <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      tree_op_t t;
      t.op = op_t'(op);
      t.lo = low_index;
      t.hi = high_index;
      t.val = value;
      apply_tree_op(t);
      items_sent++;
    end
    if (!rst && out_valid && !out_stall) begin
      queries_seen++;
      if (min_q.size() == 0) begin
        $error("min_value: unexpected transfer, actual %0d", min_value);
        errors++;
      end else begin
        logic signed [DATA_W-1:0] want;
        want = min_q.pop_front();
        if (want !== min_value) begin
          $error("min_value: expected %0d, actual %0d", want, min_value);
          errors++;
        end
      end
    end
  end

  task automatic drain_and_settle();
    wait (pending.size() == 0 && !in_valid && min_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(int unsigned c);
    @(negedge clk);
    cfg_we <= 1;
    cfg_data <= c[CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
    used_elems = c[CNT_W-1:0];
  endtask

  int unsigned counts [6] = '{1024, 37, 0, 2047, 1, 1024};

  initial begin
    for (int k = 0; k < 2*LEAF_COUNT; k++) node_mirror[k] = VAL_MAX;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, every op, saturation and empty ranges
    queue_op(OP_QUERY, 0, 1023, 0);
    queue_op(OP_LOAD, 0, 0, VAL_MIN);
    queue_op(OP_LOAD, 1023, 0, VAL_MAX);
    queue_op(OP_LOAD, 5, 0, VAL_MAX - 1);
    queue_op(OP_PADD, 5, 0, 10);
    queue_op(OP_QUERY, 5, 5, 0);
    queue_op(OP_PADD, 0, 0, -1);
    queue_op(OP_LOAD, 6, 0, -7);
    queue_op(OP_RADD, 4, 8, VAL_MIN);
    queue_op(OP_QUERY, 1, 9, 0);
    queue_op(OP_RADD, 9, 3, 100);
    queue_op(OP_QUERY, 9, 3, 0);
    queue_op(OP_QUERY, 0, 1023, 0);
    queue_op(OP_RADD, 1000, 1023, VAL_MAX);
    queue_op(OP_QUERY, 1000, 1023, 0);
    queue_op(OP_PADD, 1023, 0, VAL_MAX);
    queue_op(OP_QUERY, 1023, 1023, 0);

    for (int ph = 0; ph < 6; ph++) begin
      int span;
      if (ph > 0) write_count(counts[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      span = (counts[ph] == 0 || counts[ph] >= LEAF_COUNT) ? LEAF_COUNT : counts[ph] + 4;
      if (ph == 0) begin
        // long output hold-off while the sender keeps offering
        fork
          begin
            hold_output = 1;
            repeat (4000) @(posedge clk);
            hold_output = 0;
          end
        join_none
      end
      if (counts[ph] == 0) begin
        queue_op(OP_QUERY, 0, 1023, 0);
        queue_op(OP_LOAD, 0, 0, -3);
      end
      for (int n = 0; n < 200; n++) pending.push_back(random_tree_op(span));
      drain_and_settle();
    end

    $display("Sent %0d transfers over %0d element_count settings, %0d query results checked.",
             items_sent, 6, queries_seen);
    if (errors == 0 && min_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

### filelist.f
rtl/rmst_pkg.sv
rtl/rmst_ram.sv
rtl/range_min_segment_tree.sv
test/tb.sv
